/* hw/rtl/utf8d_pkg.sv */
package utf8d_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 31;
  localparam int unsigned CountW  = 3;
  localparam int unsigned DataW   = 32;  // code point padded to whole bytes

  typedef logic [CpW-1:0]    cp_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_MALFORMED   = 2'd1,
    ST_INVALID     = 2'd2
  } status_t;

  localparam count_t MaxLeft = 3'd5;

endpackage

/* hw/rtl/utf8_code_point_decoder.sv */
// Channel  | Dir | Handshake              | Payload
// s_axis   | in  | s_axis_tvalid / tready | tdata[7:0] in_byte
// m_axis   | out | m_axis_tvalid / tready | tdata[30:0] code_point, tuser[1:0] status
//
// One byte is taken every cycle while the output is not stalled; a result leaves in
// the cycle after the byte that completes it, from a single output register.
// The decode state (count, accumulator, error flag) updates on the input
// transfer, so there is no bubble between sequences.
// s_axis_tready is low only while the output register holds a result that
// m_axis_tready does not take; a stall on the output side stops the input.
// rst clears the decode state and the output valid flag.
module utf8_code_point_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [utf8d_pkg::ByteW-1:0]     s_axis_tdata,   // [7:0] in_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [utf8d_pkg::DataW-1:0]     m_axis_tdata,   // [30:0] code_point, [31] zero
  output logic [1:0]                      m_axis_tuser    // [1:0] status
);
  import utf8d_pkg::*;

  count_t  bytes_left, bytes_left_next;
  cp_t     accumulator, accumulator_next;
  logic    bad_continuation, bad_continuation_next;

  logic    out_valid;
  cp_t     out_cp, cp_next;
  status_t out_status, status_next;
  logic    emit;
  logic    in_xfer;
  logic    bad_byte;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign bad_byte      = (s_axis_tdata[7:6] != 2'b10);

  always_comb begin
    bytes_left_next       = bytes_left;
    accumulator_next      = accumulator;
    bad_continuation_next = bad_continuation;
    emit                  = 1'b0;
    cp_next               = '0;
    status_next           = ST_OK;
    if (bytes_left != '0) begin
      // shift in six payload bits whatever the prefix
      accumulator_next = {accumulator[CpW-7:0], s_axis_tdata[5:0]};
      bytes_left_next  = bytes_left - count_t'(1);
      if (bytes_left == count_t'(1)) begin
        emit                  = 1'b1;
        cp_next               = accumulator_next;
        status_next           = (bad_continuation || bad_byte) ? ST_MALFORMED : ST_OK;
        bad_continuation_next = 1'b0;
      end else begin
        bad_continuation_next = bad_continuation || bad_byte;
      end
    end else begin
      casez (s_axis_tdata)
        8'b0???????: begin
          emit    = 1'b1;
          cp_next = cp_t'(s_axis_tdata);
        end
        8'b110?????: begin
          accumulator_next      = cp_t'(s_axis_tdata[4:0]);
          bytes_left_next       = count_t'(1);
          bad_continuation_next = 1'b0;
        end
        8'b1110????: begin
          accumulator_next      = cp_t'(s_axis_tdata[3:0]);
          bytes_left_next       = count_t'(2);
          bad_continuation_next = 1'b0;
        end
        8'b11110???: begin
          accumulator_next      = cp_t'(s_axis_tdata[2:0]);
          bytes_left_next       = count_t'(3);
          bad_continuation_next = 1'b0;
        end
        8'b111110??: begin
          accumulator_next      = cp_t'(s_axis_tdata[1:0]);
          bytes_left_next       = count_t'(4);
          bad_continuation_next = 1'b0;
        end
        8'b1111110?: begin
          accumulator_next      = cp_t'(s_axis_tdata[0]);
          bytes_left_next       = MaxLeft;
          bad_continuation_next = 1'b0;
        end
        default: begin
          // stray continuation or 0xFE/0xFF: report, keep state
          emit        = 1'b1;
          status_next = ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left       <= '0;
      accumulator      <= '0;
      bad_continuation <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (in_xfer) begin
        bytes_left       <= bytes_left_next;
        accumulator      <= accumulator_next;
        bad_continuation <= bad_continuation_next;
      end
      if (in_xfer) begin
        out_valid <= emit;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_cp     <= cp_next;
      out_status <= status_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_cp};
  assign m_axis_tuser  = out_status;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= MaxLeft)
    else $error("bytes_left out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_INVALID) |-> (out_cp == '0))
    else $error("invalid result carries nonzero code point");

  a_ascii_pass: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && bytes_left == '0 && !s_axis_tdata[7]) |=>
      (out_valid && out_status == ST_OK && out_cp == cp_t'($past(s_axis_tdata))))
    else $error("single byte not passed through");

  a_no_status3: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (m_axis_tuser != 2'd3))
    else $error("reserved status emitted");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import utf8d_pkg::*;

  localparam int RandBytes = 1750;
  localparam int CycleLimit = 500000;
  localparam int NumRows = 23;

  typedef struct packed {
    cp_t     cp;
    status_t st;
  } decoded_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    cp_t        cp;
    status_t    st;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata = '0;  // [7:0] in_byte
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;       // [30:0] code_point, [31] zero
  logic [1:0] m_axis_tuser;             // [1:0] status

  // expectation typed in the table, travels with the byte on the bus
  logic    drv_typed = 1'b0;
  cp_t     drv_cp = '0;
  status_t drv_st = ST_OK;

  // decoder state of the predictor
  count_t left_cnt = '0;
  cp_t    acc = '0;
  logic   bad_cont = 1'b0;

  decoded_t decoded_q[$];
  row_t     rows[NumRows];

  int errors = 0;
  int n_bytes = 0;
  int n_results = 0;
  int n_malformed = 0;
  int n_invalid = 0;
  int n_long_seq = 0;
  int cyc = 0;
  int tx_calm = 0;
  int max_hold = 0;
  bit rx_stall_req = 1'b0;

  utf8_code_point_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc > CycleLimit) begin
        $display("%0t: timeout after %0d cycles", $time, cyc);
        $display("utf8_code_point_decoder test failed");
        $finish;
      end
    end
  end

  task automatic decode_byte(input logic [7:0] b, output bit got, output cp_t cp,
                             output status_t st);
    got = 1'b0;
    cp = '0;
    st = ST_OK;
    if (left_cnt != 0) begin
      // any byte inside an open sequence is taken as a continuation
      if (b[7:6] != 2'b10) bad_cont = 1'b1;
      acc = {acc[CpW-7:0], b[5:0]};
      left_cnt = left_cnt - 1'b1;
      if (left_cnt == 0) begin
        got = 1'b1;
        cp = acc;
        st = bad_cont ? ST_MALFORMED : ST_OK;
        bad_cont = 1'b0;
      end
    end else begin
      casez (b)
        8'b0???????: begin
          got = 1'b1;
          cp = cp_t'(b);
        end
        8'b110?????: begin acc = cp_t'(b[4:0]); left_cnt = 3'd1; bad_cont = 1'b0; end
        8'b1110????: begin acc = cp_t'(b[3:0]); left_cnt = 3'd2; bad_cont = 1'b0; end
        8'b11110???: begin acc = cp_t'(b[2:0]); left_cnt = 3'd3; bad_cont = 1'b0; end
        8'b111110??: begin acc = cp_t'(b[1:0]); left_cnt = 3'd4; bad_cont = 1'b0; end
        8'b1111110?: begin acc = cp_t'(b[0]);   left_cnt = 3'd5; bad_cont = 1'b0; end
        default: begin
          // stray continuation or 0xFE/0xFF: state untouched
          got = 1'b1;
          st = ST_INVALID;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    bit       got;
    cp_t      cp;
    status_t  st;
    decoded_t exp;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        n_bytes++;
        decode_byte(s_axis_tdata, got, cp, st);
        if (got) begin
          if (drv_typed) exp = '{drv_cp, drv_st};
          else exp = '{cp, st};
          decoded_q = {decoded_q, exp};
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (m_axis_tuser == ST_MALFORMED) n_malformed++;
        if (m_axis_tuser == ST_INVALID) n_invalid++;
        if (decoded_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual cp=%h status=%0d",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          exp = decoded_q.pop_front();
          if (m_axis_tdata !== {1'b0, exp.cp}) begin
            errors++;
            $display("%0t: code_point expected %h actual %h", $time, {1'b0, exp.cp},
                     m_axis_tdata);
          end
          if (m_axis_tuser !== exp.st) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, exp.st, m_axis_tuser);
          end
        end
      end
    end
  end

  // receiver: random holds, calm stretches, and one long hold on request
  initial begin
    int hold;
    int calm;
    hold = 0;
    calm = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rx_stall_req) begin
        rx_stall_req = 1'b0;
        hold = 150;
      end
      if (hold > 0) begin
        if (hold > max_hold) max_hold = hold;
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (calm > 0) begin
          calm--;
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:14]:  hold = $urandom_range(1, 3);
            [15:16]: hold = $urandom_range(10, 40);
            17:      calm = $urandom_range(30, 80);
            default: ;
          endcase
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic typed, input cp_t cp,
                           input status_t st);
    int gap;
    gap = 0;
    if (tx_calm > 0) begin
      tx_calm--;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:24]:  gap = $urandom_range(1, 3);
        [25:27]: gap = $urandom_range(10, 40);
        28:      tx_calm = $urandom_range(20, 60);
        default: ;
      endcase
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    drv_typed     <= typed;
    drv_cp        <= cp;
    drv_st        <= st;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic send_rand(input logic [7:0] b);
    send_byte(b, 1'b0, '0, ST_OK);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
  endtask

  // one sequence with random payload, its continuation bytes sometimes corrupted, or a noise byte
  task automatic send_sequence(inout int sent);
    int len;
    logic [7:0] lead;
    logic [7:0] cont;
    if ($urandom_range(0, 99) < 15) begin
      send_rand(8'($urandom_range(0, 255)));
      sent++;
    end else begin
      len = $urandom_range(1, 6);
      lead = 8'($urandom);
      case (len)
        1: lead = {1'b0, lead[6:0]};
        2: lead = {3'b110, lead[4:0]};
        3: lead = {4'b1110, lead[3:0]};
        4: lead = {5'b11110, lead[2:0]};
        5: lead = {6'b111110, lead[1:0]};
        default: lead = {7'b1111110, lead[0]};
      endcase
      if (len >= 5) n_long_seq++;
      send_rand(lead);
      sent++;
      for (int i = 1; i < len; i++) begin
        cont = 8'($urandom);
        if ($urandom_range(0, 9) != 0) cont = {2'b10, cont[5:0]};
        send_rand(cont);
        sent++;
      end
    end
  endtask

  initial begin
    int sent;
    bit stalled;
    bit paused;
    sent = 0;
    stalled = 1'b0;
    paused = 1'b0;
    rows = '{
      '{8'h00, 1'b1, 31'h0, ST_OK},
      '{8'h7F, 1'b1, 31'h7F, ST_OK},
      '{8'h80, 1'b1, 31'h0, ST_INVALID},
      '{8'hBF, 1'b1, 31'h0, ST_INVALID},
      '{8'hFE, 1'b1, 31'h0, ST_INVALID},
      '{8'hFF, 1'b1, 31'h0, ST_INVALID},
      '{8'hC2, 1'b0, 31'h0, ST_OK},
      '{8'hA9, 1'b0, 31'h0, ST_OK},
      '{8'hE2, 1'b0, 31'h0, ST_OK},
      '{8'h82, 1'b0, 31'h0, ST_OK},
      '{8'hAC, 1'b0, 31'h0, ST_OK},
      '{8'hF4, 1'b0, 31'h0, ST_OK},
      '{8'h8F, 1'b0, 31'h0, ST_OK},
      '{8'hBF, 1'b0, 31'h0, ST_OK},
      '{8'hBF, 1'b0, 31'h0, ST_OK},
      '{8'hFD, 1'b0, 31'h0, ST_OK},
      '{8'hBF, 1'b0, 31'h0, ST_OK},
      '{8'hBF, 1'b0, 31'h0, ST_OK},
      '{8'hBF, 1'b0, 31'h0, ST_OK},
      '{8'hBF, 1'b0, 31'h0, ST_OK},
      '{8'hBF, 1'b1, 31'h7FFF_FFFF, ST_OK},
      // lead byte where a continuation belongs
      '{8'hC3, 1'b0, 31'h0, ST_OK},
      '{8'hF0, 1'b0, 31'h0, ST_OK}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NumRows; i++) begin
      send_byte(rows[i].b, rows[i].typed, rows[i].cp, rows[i].st);
    end

    while (sent < RandBytes) begin
      if (!stalled && sent > 600) begin
        // keep offering while the output side is held off
        stalled = 1'b1;
        tx_calm = 40;
        rx_stall_req = 1'b1;
      end
      if (!paused && sent > 1200) begin
        paused = 1'b1;
        wait_drained();
      end
      send_sequence(sent);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (decoded_q.size() != 0) begin
      errors += decoded_q.size();
      $display("%0t: %0d expected results never arrived", $time, decoded_q.size());
    end
    $display("Decoded %0d bytes into %0d results (%0d malformed, %0d invalid).",
             n_bytes, n_results, n_malformed, n_invalid);
    $display("Covered %0d five/six-byte sequences; longest output hold %0d cycles.",
             n_long_seq, max_hold);
    if (errors == 0) begin
      $display("utf8_code_point_decoder test passed");
    end else begin
      $display("utf8_code_point_decoder test failed");
    end
    $finish;
  end

endmodule
